/* rtl/wavhp_pkg.sv */
// Shared types, tags and constants for the RIFF/WAVE header parser.
package wavhp_pkg;

	localparam logic [31:0] TAG_RIFF = 32'h52494646;
	localparam logic [31:0] TAG_WAVE = 32'h57415645;
	localparam logic [31:0] TAG_FMT  = 32'h666D7420;
	localparam logic [31:0] TAG_DATA = 32'h64617461;

	localparam logic [31:0] FMT_BODY_LEN = 32'd16;
	localparam int          DUR_W        = 42;
	localparam int          CNT_W        = $clog2(DUR_W);
	localparam logic [9:0]  MS_PER_S     = 10'd1000;

	// Parse phases; the codes past PH_DONE are never entered
	typedef enum logic [2:0] {
		PH_RIFF = 3'd0,
		PH_HDR  = 3'd1,
		PH_FMT  = 3'd2,
		PH_SKIP = 3'd3,
		PH_DONE = 3'd4
	} phase_t;

	// Divider sequencer states
	typedef enum logic [1:0] {
		DIV_IDLE = 2'd0,
		DIV_MUL  = 2'd1,
		DIV_STEP = 2'd2,
		DIV_DONE = 2'd3
	} div_state_t;

	// Everything the parser hands over when a parse ends
	typedef struct packed {
		logic        header_ok;
		logic        format_found;
		logic        data_seen;
		logic [15:0] channels;
		logic [31:0] rate;
		logic [31:0] byte_rate;
		logic [15:0] width;
		logic [31:0] data_len;
	} wavhp_result_t;

endpackage

/* rtl/wavhp_parser.sv */
// Byte-serial chunk walker: header check, fmt capture, chunk skipping.
module wavhp_parser import wavhp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          byte_valid,
	input  logic [7:0]    file_byte,
	input  logic          last_byte,
	output logic          emit,
	output wavhp_result_t result
);

	phase_t      phase_q, phase_n;
	logic [3:0]  pos_q, pos_n;
	logic [32:0] skip_q, skip_n;
	logic [31:0] tag_q, tag_n;
	logic [31:0] len_q, len_n;
	logic [15:0] chan_q, chan_n;
	logic [31:0] rate_q, rate_n;
	logic [31:0] brate_q, brate_n;
	logic [15:0] width_q, width_n;
	logic [2:0]  flags_q, flags_n;
	logic [15:0] st_chan_q, st_chan_n;
	logic [31:0] st_rate_q, st_rate_n;
	logic [31:0] st_brate_q, st_brate_n;
	logic [15:0] st_width_q, st_width_n;
	logic        done;
	logic        live;

	// Hold the parse state; advance one byte per accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_RIFF;
			pos_q      <= '0;
			skip_q     <= '0;
			tag_q      <= '0;
			len_q      <= '0;
			chan_q     <= '0;
			rate_q     <= '0;
			brate_q    <= '0;
			width_q    <= '0;
			flags_q    <= '0;
			st_chan_q  <= '0;
			st_rate_q  <= '0;
			st_brate_q <= '0;
			st_width_q <= '0;
		end else if (byte_valid) begin
			phase_q    <= phase_n;
			pos_q      <= pos_n;
			skip_q     <= skip_n;
			tag_q      <= tag_n;
			len_q      <= len_n;
			chan_q     <= chan_n;
			rate_q     <= rate_n;
			brate_q    <= brate_n;
			width_q    <= width_n;
			flags_q    <= flags_n;
			st_chan_q  <= st_chan_n;
			st_rate_q  <= st_rate_n;
			st_brate_q <= st_brate_n;
			st_width_q <= st_width_n;
		end
	end

	// Work out the next state for the current byte
	always_comb begin
		phase_n    = phase_q;
		pos_n      = pos_q;
		skip_n     = skip_q;
		tag_n      = tag_q;
		len_n      = len_q;
		chan_n     = chan_q;
		rate_n     = rate_q;
		brate_n    = brate_q;
		width_n    = width_q;
		flags_n    = flags_q;
		st_chan_n  = st_chan_q;
		st_rate_n  = st_rate_q;
		st_brate_n = st_brate_q;
		st_width_n = st_width_q;
		done       = 1'b0;
		live       = 1'b1;

		case (phase_q)
			PH_RIFF: begin
				tag_n = {tag_q[23:0], file_byte};
				// remember whether the first tag matched
				if (pos_q == 4'd3) begin
					skip_n = (tag_n == TAG_RIFF) ? 33'd1 : 33'd0;
				end
				if (pos_q >= 4'd11) begin
					if (skip_n == 33'd1 && tag_n == TAG_WAVE) begin
						flags_n[0] = 1'b1;
						phase_n    = PH_HDR;
					end else begin
						done = 1'b1;
					end
					skip_n = '0;
					pos_n  = '0;
				end else begin
					pos_n = pos_q + 4'd1;
				end
			end
			PH_HDR: begin
				if (pos_q < 4'd4) begin
					tag_n = {tag_q[23:0], file_byte};
				end else if (pos_q == 4'd4) begin
					len_n = {24'd0, file_byte};
				end else begin
					len_n[{pos_q[1:0], 3'b000} +: 8] = file_byte;
				end
				if (pos_q >= 4'd7) begin
					pos_n = '0;
					if (tag_n == TAG_FMT) begin
						if (len_n < FMT_BODY_LEN) begin
							done = 1'b1;
						end else begin
							skip_n = (len_n > FMT_BODY_LEN)
								? {1'b0, len_n - FMT_BODY_LEN} + {32'd0, len_n[0]}
								: 33'd0;
							phase_n = PH_FMT;
						end
					end else if (tag_n == TAG_DATA) begin
						flags_n[2] = 1'b1;
						done       = 1'b1;
					end else begin
						skip_n  = {1'b0, len_n} + {32'd0, len_n[0]};
						phase_n = (skip_n != 33'd0) ? PH_SKIP : PH_HDR;
					end
				end else begin
					pos_n = pos_q + 4'd1;
				end
			end
			PH_FMT: begin
				// stage the body fields byte by byte
				case (pos_q)
					4'd2:                begin st_chan_n = {8'd0, file_byte}; end
					4'd3:                begin st_chan_n[15:8] = file_byte; end
					4'd4:                begin st_rate_n = {24'd0, file_byte}; end
					4'd5, 4'd6, 4'd7:    begin
						st_rate_n[{pos_q[1:0], 3'b000} +: 8] = file_byte;
					end
					4'd8:                begin st_brate_n = {24'd0, file_byte}; end
					4'd9, 4'd10, 4'd11:  begin
						st_brate_n[{pos_q[1:0], 3'b000} +: 8] = file_byte;
					end
					4'd14:               begin st_width_n = {8'd0, file_byte}; end
					4'd15:               begin st_width_n[15:8] = file_byte; end
					default:             begin end
				endcase
				// commit the body once all of it is in
				if (pos_q == 4'd15) begin
					chan_n     = st_chan_n;
					rate_n     = st_rate_n;
					brate_n    = st_brate_n;
					width_n    = st_width_n;
					flags_n[1] = 1'b1;
					pos_n      = '0;
					phase_n    = (skip_q != 33'd0) ? PH_SKIP : PH_HDR;
				end else begin
					pos_n = pos_q + 4'd1;
				end
			end
			PH_SKIP: begin
				if (skip_q != 33'd0) begin
					skip_n = skip_q - 33'd1;
				end
				if (skip_n == 33'd0) begin
					phase_n = PH_HDR;
				end
			end
			default: begin
				// parse over: drop bytes until the file ends
				live = 1'b0;
			end
		endcase

		emit = live && (done || last_byte);

		// result reflects the state after this byte
		result.header_ok    = flags_n[0];
		result.format_found = flags_n[1];
		result.data_seen    = flags_n[2];
		result.channels     = chan_n;
		result.rate         = rate_n;
		result.byte_rate    = brate_n;
		result.width        = width_n;
		result.data_len     = len_n;

		// start over on the last byte, else park once the parse ends
		if (last_byte) begin
			phase_n    = PH_RIFF;
			pos_n      = '0;
			skip_n     = '0;
			tag_n      = '0;
			len_n      = '0;
			chan_n     = '0;
			rate_n     = '0;
			brate_n    = '0;
			width_n    = '0;
			flags_n    = '0;
			st_chan_n  = '0;
			st_rate_n  = '0;
			st_brate_n = '0;
			st_width_n = '0;
		end else if (done) begin
			phase_n = PH_DONE;
		end
	end

endmodule

/* rtl/wavhp_divider.sv */
// Multiply-then-divide unit: data length times 1000 over byte rate.
module wavhp_divider import wavhp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [31:0]      data_len,
	input  logic [31:0]      byte_rate,
	output logic             busy,
	output logic             done,
	output logic [DUR_W-1:0] quotient
);

	div_state_t       state_q, state_n;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0]      len_q;
	logic [31:0]      div_q;
	logic [DUR_W-1:0] quo_q;
	logic [31:0]      rem_q;
	logic [32:0]      rem_sh;
	logic             fits;

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Step through load, multiply, one quotient bit per cycle, finish
	always_comb begin
		state_n = state_q;
		case (state_q)
			DIV_IDLE: begin
				if (start) begin
					state_n = DIV_MUL;
				end
			end
			DIV_MUL: begin
				state_n = DIV_STEP;
			end
			DIV_STEP: begin
				if (cnt_q == CNT_W'(DUR_W - 1)) begin
					state_n = DIV_DONE;
				end
			end
			DIV_DONE: begin
				state_n = DIV_IDLE;
			end
			default: begin
				state_n = DIV_IDLE;
			end
		endcase
	end

	// Shift in the next dividend bit and try the subtract
	assign rem_sh = {rem_q, quo_q[DUR_W-1]};
	assign fits   = rem_sh >= {1'b0, div_q};

	// Advance the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (state_q)
				DIV_MUL:  begin cnt_q <= '0; end
				DIV_STEP: begin cnt_q <= cnt_q + CNT_W'(1); end
				default:  begin end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			DIV_IDLE: begin
				if (start) begin
					len_q <= data_len;
					div_q <= byte_rate;
				end
			end
			DIV_MUL: begin
				quo_q <= DUR_W'(len_q) * DUR_W'(MS_PER_S);
				rem_q <= '0;
			end
			DIV_STEP: begin
				if (fits) begin
					rem_q <= 32'(rem_sh - {1'b0, div_q});
				end else begin
					rem_q <= rem_sh[31:0];
				end
				quo_q <= {quo_q[DUR_W-2:0], fits};
			end
			default: begin end
		endcase
	end

	assign busy     = state_q != DIV_IDLE;
	assign done     = state_q == DIV_DONE;
	assign quotient = quo_q;

endmodule

/* rtl/wav_header_parser.sv */
// Timing: bytes are taken one per cycle while the parse runs; the result is shown in
// the cycle after the ending byte, or after the divider's load, multiply, 42 quotient
// steps and finish when a duration is computed. Throughput: 1 byte per cycle; input
// stalls while a result waits and while the divider runs, more under out_stall.
// Reset: arst_n clears the sequencer, the divider and the output beat at once;
// the parser returns to the RIFF header phase with all held fields zero.
module wav_header_parser import wavhp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       file_byte,
	input  logic             last_byte,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             header_ok,
	output logic             format_found,
	output logic [15:0]      channel_count,
	output logic [31:0]      sample_rate,
	output logic [15:0]      bits_per_sample,
	output logic             duration_found,
	output logic [DUR_W-1:0] duration_ms
);

	logic             accept;
	logic             emit;
	wavhp_result_t    result;
	logic             dur_ok;
	logic             div_start;
	logic             div_busy;
	logic             div_done;
	logic [DUR_W-1:0] quotient;
	logic             out_valid_q;
	logic             header_ok_q;
	logic             format_found_q;
	logic [15:0]      channel_count_q;
	logic [31:0]      sample_rate_q;
	logic [15:0]      bits_per_sample_q;
	logic             duration_found_q;
	logic [DUR_W-1:0] duration_ms_q;

	// Hold off input while a duration is worked out or a result waits
	assign in_stall  = div_busy || out_valid_q;
	assign accept    = in_valid && !in_stall;
	assign dur_ok    = result.data_seen && (result.byte_rate != 32'd0);
	assign div_start = accept && emit && dur_ok;

	wavhp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (accept),
		.file_byte  (file_byte),
		.last_byte  (last_byte),
		.emit       (emit),
		.result     (result)
	);

	wavhp_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.data_len  (result.data_len),
		.byte_rate (result.byte_rate),
		.busy      (div_busy),
		.done      (div_done),
		.quotient  (quotient)
	);

	// Raise the output beat when the result is complete, drop it when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && emit && !dur_ok) begin
			out_valid_q <= 1'b1;
		end else if (div_done) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Capture result fields at the end of the parse
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			header_ok_q       <= result.header_ok;
			format_found_q    <= result.format_found;
			channel_count_q   <= result.channels;
			sample_rate_q     <= result.rate;
			bits_per_sample_q <= result.width;
			duration_found_q  <= dur_ok;
			duration_ms_q     <= '0;
		end else if (div_done) begin
			duration_ms_q <= quotient;
		end
	end

	assign out_valid       = out_valid_q;
	assign header_ok       = header_ok_q;
	assign format_found    = format_found_q;
	assign channel_count   = channel_count_q;
	assign sample_rate     = sample_rate_q;
	assign bits_per_sample = bits_per_sample_q;
	assign duration_found  = duration_found_q;
	assign duration_ms     = duration_ms_q;

endmodule
